/* rtl/tsfam_pkg.sv */
// tsfam_pkg: shared constants and helpers for the touch sample filter and affine map
// holds widths, register indexes, reset values, median and floor/saturate helpers
// no dependencies
package tsfam_pkg;

	localparam int SAMPLE_W       = 12;
	localparam int COEF_FRAC_BITS = 20;
	localparam int COEF_W         = 32;
	localparam int LIMIT_W        = 27;
	localparam int SCREEN_W       = 16;
	localparam int PADDR_W        = 5;
	localparam int PDATA_W        = 32;
	localparam int S_TDATA_W      = 8 * SAMPLE_W;
	localparam int M_TDATA_W      = 2 * SCREEN_W;
	localparam int MUL_B_W        = SAMPLE_W + 1;
	localparam int PROD_W         = COEF_W + MUL_B_W;
	localparam int ACC_W          = PROD_W + 3;
	localparam int CONTACT_W      = 2 * SAMPLE_W + 4;

	// register indexes (byte address is 4 * index)
	localparam logic [2:0] REG_CXX   = 3'd0;
	localparam logic [2:0] REG_CXY   = 3'd1;
	localparam logic [2:0] REG_OX    = 3'd2;
	localparam logic [2:0] REG_CYX   = 3'd3;
	localparam logic [2:0] REG_CYY   = 3'd4;
	localparam logic [2:0] REG_OY    = 3'd5;
	localparam logic [2:0] REG_LIMIT = 3'd6;

	localparam logic signed [COEF_W-1:0] RST_CXX   = 32'sd150185;
	localparam logic signed [COEF_W-1:0] RST_CXY   = -32'sd1850;
	localparam logic signed [COEF_W-1:0] RST_OX    = -32'sd42120470;
	localparam logic signed [COEF_W-1:0] RST_CYX   = 32'sd75;
	localparam logic signed [COEF_W-1:0] RST_CYY   = -32'sd97518;
	localparam logic signed [COEF_W-1:0] RST_OY    = 32'sd334841774;
	localparam logic [LIMIT_W-1:0]       RST_LIMIT = 27'd16384;

	localparam logic signed [ACC_W-1:0] SAT_MAX = ACC_W'(32767);
	localparam logic signed [ACC_W-1:0] SAT_MIN = -ACC_W'(32768);

	typedef logic [SAMPLE_W-1:0] sample_t;
	typedef logic signed [SCREEN_W-1:0] screen_t;

	function automatic sample_t median3(input sample_t a, input sample_t b, input sample_t c);
		sample_t lo;
		sample_t hi;
		lo = (a < b) ? a : b;
		hi = (a < b) ? b : a;
		if (c <= lo) begin
			return lo;
		end else if (c >= hi) begin
			return hi;
		end
		return c;
	endfunction

	// arithmetic shift floors toward minus infinity, then clamp to 16 bits
	function automatic screen_t floor_sat(input logic signed [ACC_W-1:0] v);
		logic signed [ACC_W-1:0] sh;
		sh = v >>> COEF_FRAC_BITS;
		if (sh > SAT_MAX) begin
			return screen_t'(SAT_MAX);
		end else if (sh < SAT_MIN) begin
			return screen_t'(SAT_MIN);
		end
		return sh[SCREEN_W-1:0];
	endfunction

endpackage

/* rtl/touch_sample_filter_affine_map_top.sv */
// touch_sample_filter_affine_map_top: a press passes through the accept, 12 divider steps,
// 6 multiply steps and the output load; a release goes from the accept to the output load
// one request at a time: the next is taken once a press, contact rejection, release or
// silent poll is done, and not while a result waits for m_tready
// arst_n clears control, pen state, last coordinates and loads calibration defaults
// depends on tsfam_pkg
module touch_sample_filter_affine_map_top (
	input  logic                              clk,
	input  logic                              arst_n,
	// request channel
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// pressure_one, pressure_two, raw_x_first, raw_x_second, raw_x_third,
	// raw_y_first, raw_y_second, raw_y_third (12 bits each, low bits first)
	input  logic [tsfam_pkg::S_TDATA_W-1:0]   s_tdata,
	// pen_down
	input  logic                              s_tuser,
	// result channel
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// screen_x [15:0], screen_y [31:16]
	output logic [tsfam_pkg::M_TDATA_W-1:0]   m_tdata,
	// touched
	output logic                              m_tuser,
	// calibration register port
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [tsfam_pkg::PADDR_W-1:0]     paddr,
	input  logic [tsfam_pkg::PDATA_W-1:0]     pwdata,
	output logic [tsfam_pkg::PDATA_W-1:0]     prdata,
	output logic                              pready
);
	import tsfam_pkg::*;

	// sequencer states
	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_DIV  = 2'd1;
	localparam logic [1:0] ST_MUL  = 2'd2;
	localparam logic [1:0] ST_OUT  = 2'd3;

	// multiply steps
	localparam logic [2:0] MS_CONTACT = 3'd0;
	localparam logic [2:0] MS_XX      = 3'd1;
	localparam logic [2:0] MS_XY      = 3'd2;
	localparam logic [2:0] MS_YX      = 3'd3;
	localparam logic [2:0] MS_YY      = 3'd4;
	localparam logic [2:0] MS_LAST    = 3'd5;

	localparam logic [3:0] DIV_LAST = 4'(SAMPLE_W - 1);

	// calibration registers
	logic signed [COEF_W-1:0] cxx_q, cxy_q, ox_q, cyx_q, cyy_q, oy_q;
	logic [LIMIT_W-1:0]       limit_q;

	// control
	logic [1:0] state_q;
	logic [3:0] div_cnt_q;
	logic [2:0] step_q;
	logic       was_pressed_q;

	// working registers
	sample_t                  x_q, y_q, z1_q, quo_q, rem_q;
	logic signed [PROD_W-1:0] prod_q;
	logic signed [ACC_W-1:0]  acc_q;
	screen_t                  last_x_q, last_y_q, pend_x_q, pend_y_q;
	logic                     pend_touched_q;

	// output register
	logic                 m_tvalid_q;
	logic                 m_tuser_q;
	logic [M_TDATA_W-1:0] m_tdata_q;

	// unpacked request fields
	sample_t z1_in, z2_in;
	sample_t x_med, y_med;

	assign z1_in = s_tdata[SAMPLE_W-1:0];
	assign z2_in = s_tdata[2*SAMPLE_W-1:SAMPLE_W];
	assign x_med = median3(s_tdata[3*SAMPLE_W-1:2*SAMPLE_W], s_tdata[4*SAMPLE_W-1:3*SAMPLE_W],
		s_tdata[5*SAMPLE_W-1:4*SAMPLE_W]);
	assign y_med = median3(s_tdata[6*SAMPLE_W-1:5*SAMPLE_W], s_tdata[7*SAMPLE_W-1:6*SAMPLE_W],
		s_tdata[8*SAMPLE_W-1:7*SAMPLE_W]);

	logic req_acc;
	assign s_tready = (state_q == ST_IDLE);
	assign req_acc  = s_tvalid && s_tready;

	// result register loads when the pending result has somewhere to go
	logic out_load;
	assign out_load = (state_q == ST_OUT) && (!m_tvalid_q || m_tready);

	// config write strobe and register select
	logic       cfg_wr;
	logic [2:0] cfg_idx;
	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite && pready;
	assign cfg_idx = paddr[PADDR_W-1:2];

	always_comb begin
		unique case (cfg_idx)
			REG_CXX:   prdata = cxx_q;
			REG_CXY:   prdata = cxy_q;
			REG_OX:    prdata = ox_q;
			REG_CYX:   prdata = cyx_q;
			REG_CYY:   prdata = cyy_q;
			REG_OY:    prdata = oy_q;
			REG_LIMIT: prdata = PDATA_W'(limit_q);
			default:   prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cxx_q   <= RST_CXX;
			cxy_q   <= RST_CXY;
			ox_q    <= RST_OX;
			cyx_q   <= RST_CYX;
			cyy_q   <= RST_CYY;
			oy_q    <= RST_OY;
			limit_q <= RST_LIMIT;
		end else if (cfg_wr) begin
			unique case (cfg_idx)
				REG_CXX:   cxx_q   <= pwdata;
				REG_CXY:   cxy_q   <= pwdata;
				REG_OX:    ox_q    <= pwdata;
				REG_CYX:   cyx_q   <= pwdata;
				REG_CYY:   cyy_q   <= pwdata;
				REG_OY:    oy_q    <= pwdata;
				REG_LIMIT: limit_q <= pwdata[LIMIT_W-1:0];
				default:   ; // addresses past the register file are ignored
			endcase
		end
	end

	// restoring divider step: shift one dividend bit into the remainder
	logic [SAMPLE_W:0] div_trial;
	logic              div_ge;
	assign div_trial = {rem_q, quo_q[SAMPLE_W-1]};
	assign div_ge    = (div_trial >= {1'b0, z1_q});

	// shared multiplier, operands chosen by the step counter
	logic signed [COEF_W-1:0]  mul_a;
	logic signed [MUL_B_W-1:0] mul_b;
	logic signed [PROD_W-1:0]  mul_p;

	always_comb begin
		case (step_q)
			MS_CONTACT: begin
				mul_a = $signed(COEF_W'(quo_q - sample_t'(1)));
				mul_b = $signed({1'b0, x_q});
			end
			MS_XX: begin
				mul_a = cxx_q;
				mul_b = $signed({1'b0, x_q});
			end
			MS_XY: begin
				mul_a = cxy_q;
				mul_b = $signed({1'b0, y_q});
			end
			MS_YX: begin
				mul_a = cyx_q;
				mul_b = $signed({1'b0, x_q});
			end
			MS_YY: begin
				mul_a = cyy_q;
				mul_b = $signed({1'b0, y_q});
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign mul_p = mul_a * mul_b;

	// contact value 5*x*(q-1), only meaningful for q >= 1 (product is then non-negative)
	logic [CONTACT_W-1:0]    contact;
	logic                    reject;
	logic signed [ACC_W-1:0] acc_sum;
	assign contact = {prod_q[CONTACT_W-3:0], 2'b00} + {2'b00, prod_q[CONTACT_W-3:0]};
	assign reject  = (quo_q != '0) && (contact > CONTACT_W'(limit_q));
	assign acc_sum = acc_q + ACC_W'(prod_q);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			div_cnt_q      <= '0;
			step_q         <= MS_CONTACT;
			was_pressed_q  <= 1'b0;
			last_x_q       <= '0;
			last_y_q       <= '0;
			pend_touched_q <= 1'b0;
			m_tvalid_q     <= 1'b0;
		end else begin
			if (out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tvalid_q && m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (req_acc) begin
						if (s_tuser) begin
							// zero pressure rejects the poll outright
							if (z1_in != '0) begin
								state_q   <= ST_DIV;
								div_cnt_q <= '0;
							end
						end else if (was_pressed_q) begin
							// pen lifted after a press: one release with the last position
							was_pressed_q  <= 1'b0;
							pend_touched_q <= 1'b0;
							state_q        <= ST_OUT;
						end
					end
				end
				ST_DIV: begin
					div_cnt_q <= div_cnt_q + 4'd1;
					if (div_cnt_q == DIV_LAST) begin
						state_q <= ST_MUL;
						step_q  <= MS_CONTACT;
					end
				end
				ST_MUL: begin
					step_q <= step_q + 3'd1;
					if (step_q == MS_XX && reject) begin
						state_q <= ST_IDLE;
					end else if (step_q == MS_LAST) begin
						was_pressed_q  <= 1'b1;
						pend_touched_q <= 1'b1;
						last_x_q       <= pend_x_q;
						last_y_q       <= floor_sat(acc_sum);
						state_q        <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (req_acc) begin
			z1_q  <= z1_in;
			quo_q <= z2_in;
			rem_q <= '0;
			x_q   <= x_med;
			y_q   <= y_med;
		end
		if (state_q == ST_DIV) begin
			rem_q <= div_ge ? SAMPLE_W'(div_trial - {1'b0, z1_q}) : div_trial[SAMPLE_W-1:0];
			quo_q <= {quo_q[SAMPLE_W-2:0], div_ge};
		end
		if (state_q == ST_MUL) begin
			prod_q <= mul_p;
			case (step_q)
				MS_XX:   acc_q <= ACC_W'(ox_q);
				MS_XY:   acc_q <= acc_sum;
				MS_YX: begin
					pend_x_q <= floor_sat(acc_sum);
					acc_q    <= ACC_W'(oy_q);
				end
				MS_YY:   acc_q <= acc_sum;
				default: ;
			endcase
		end
		if (state_q == ST_MUL && step_q == MS_LAST) begin
			pend_y_q <= floor_sat(acc_sum);
		end
		if (out_load) begin
			m_tuser_q <= pend_touched_q;
			m_tdata_q <= pend_touched_q ? {pend_y_q, pend_x_q} : {last_y_q, last_x_q};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tuser  = m_tuser_q;
	assign m_tdata  = m_tdata_q;

`ifndef ASSERT_OFF
	// the divider never runs with a zero divisor
	a_div_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) |-> (z1_q != '0))
		else $error("divider started with zero pressure");

	// the divider hands over to the multiply steps after exactly one pass over the bits
	a_div_to_mul: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV && div_cnt_q == DIV_LAST) |=>
		(state_q == ST_MUL && step_q == MS_CONTACT))
		else $error("divider did not hand over to multiplier");

	// a fresh result agrees with the pen state it leaves behind
	a_kind_matches_pen: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid_q) |-> (m_tuser_q == was_pressed_q))
		else $error("result kind disagrees with pen state");

	// a request is only taken in idle with no multiply step pending
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MUL) |=> !(state_q == ST_DIV))
		else $error("multiplier steps interrupted by a new division");
`endif

endmodule

/* sim/touch_event_checker.sv */
// touch_event_checker: watches the poll, result and calibration channels of the touch filter
// predicts every press and release, compares results field by field, counts mismatches
// depends on tsfam_pkg
module touch_event_checker (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	input  logic                             s_tready,
	input  logic [tsfam_pkg::S_TDATA_W-1:0]  s_tdata,
	input  logic                             s_tuser,
	input  logic                             m_tvalid,
	input  logic                             m_tready,
	input  logic [tsfam_pkg::M_TDATA_W-1:0]  m_tdata,
	input  logic                             m_tuser,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic                             pready,
	input  logic [tsfam_pkg::PADDR_W-1:0]    paddr,
	input  logic [tsfam_pkg::PDATA_W-1:0]    pwdata,
	output int                               fail_count,
	output int                               pending
);
	timeunit 1ns;
	timeprecision 1ps;

	import tsfam_pkg::*;

	typedef struct packed {
		logic    touched;
		screen_t screen_x;
		screen_t screen_y;
	} touch_event_t;

	logic signed [COEF_W-1:0] coef [0:5];
	logic [LIMIT_W-1:0]       limit;
	bit                       pen_held;
	screen_t                  held_x;
	screen_t                  held_y;
	touch_event_t             expected_events[$];
	touch_event_t             due;
	screen_t                  got_x;
	screen_t                  got_y;

	initial fail_count = 0;

	task automatic report_mismatch(input string msg);
		fail_count++;
		if (fail_count <= 100) begin
			$display("%0t ns mismatch: %s", $time, msg);
		end
	endtask

	function automatic sample_t middle_of_three(input sample_t a, input sample_t b,
			input sample_t c);
		sample_t lo;
		sample_t hi;
		lo = (a < b) ? a : b;
		hi = (a < b) ? b : a;
		// clamp c into [lo, hi]
		return (c < lo) ? lo : ((c > hi) ? hi : c);
	endfunction

	function automatic screen_t map_to_screen(input longint gain_x, input longint gain_y,
			input longint offset, input longint x, input longint y);
		longint acc;
		acc = (gain_x * x + gain_y * y + offset) >>> COEF_FRAC_BITS;
		if (acc > 32767) begin
			return screen_t'(32767);
		end
		if (acc < -32768) begin
			return screen_t'(-32768);
		end
		return screen_t'(acc);
	endfunction

	task automatic predict_touch_event(input logic pen, input logic [S_TDATA_W-1:0] d);
		sample_t z1;
		sample_t z2;
		longint  x;
		longint  y;
		longint  ratio;
		longint  contact;
		z1 = d[0 +: SAMPLE_W];
		z2 = d[SAMPLE_W +: SAMPLE_W];
		if (pen) begin
			if (z1 == 0) begin
				return;
			end
			x = longint'(middle_of_three(d[2*SAMPLE_W +: SAMPLE_W], d[3*SAMPLE_W +: SAMPLE_W],
				d[4*SAMPLE_W +: SAMPLE_W]));
			y = longint'(middle_of_three(d[5*SAMPLE_W +: SAMPLE_W], d[6*SAMPLE_W +: SAMPLE_W],
				d[7*SAMPLE_W +: SAMPLE_W]));
			ratio = longint'(z2) / longint'(z1);
			contact = 5 * x * (ratio - 1);
			if (contact > longint'(limit)) begin
				return;
			end
			held_x = map_to_screen(longint'(coef[REG_CXX]), longint'(coef[REG_CXY]),
				longint'(coef[REG_OX]), x, y);
			held_y = map_to_screen(longint'(coef[REG_CYX]), longint'(coef[REG_CYY]),
				longint'(coef[REG_OY]), x, y);
			pen_held = 1'b1;
			expected_events.push_back('{1'b1, held_x, held_y});
		end else if (pen_held) begin
			pen_held = 1'b0;
			expected_events.push_back('{1'b0, held_x, held_y});
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef[REG_CXX] = RST_CXX;
			coef[REG_CXY] = RST_CXY;
			coef[REG_OX]  = RST_OX;
			coef[REG_CYX] = RST_CYX;
			coef[REG_CYY] = RST_CYY;
			coef[REG_OY]  = RST_OY;
			limit         = RST_LIMIT;
			pen_held      = 1'b0;
			held_x        = '0;
			held_y        = '0;
			expected_events.delete();
			pending       = 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (paddr[PADDR_W-1:2])
					REG_CXX:   coef[REG_CXX] = pwdata;
					REG_CXY:   coef[REG_CXY] = pwdata;
					REG_OX:    coef[REG_OX]  = pwdata;
					REG_CYX:   coef[REG_CYX] = pwdata;
					REG_CYY:   coef[REG_CYY] = pwdata;
					REG_OY:    coef[REG_OY]  = pwdata;
					REG_LIMIT: limit         = pwdata[LIMIT_W-1:0];
					default: ;
				endcase
			end
			// results first: a result on the same edge belongs to an earlier request
			if (m_tvalid && m_tready) begin
				got_x = m_tdata[0 +: SCREEN_W];
				got_y = m_tdata[SCREEN_W +: SCREEN_W];
				if (expected_events.size() == 0) begin
					report_mismatch($sformatf("unexpected result touched %0b x %0d y %0d",
						m_tuser, got_x, got_y));
				end else begin
					due = expected_events.pop_front();
					if (m_tuser !== due.touched) begin
						report_mismatch($sformatf("touched %0b, expected %0b", m_tuser,
							due.touched));
					end
					if (got_x !== due.screen_x) begin
						report_mismatch($sformatf("screen_x %0d, expected %0d", got_x,
							due.screen_x));
					end
					if (got_y !== due.screen_y) begin
						report_mismatch($sformatf("screen_y %0d, expected %0d", got_y,
							due.screen_y));
					end
				end
			end
			if (s_tvalid && s_tready) begin
				predict_touch_event(s_tuser, s_tdata);
			end
			pending = expected_events.size();
		end
	end

endmodule

/* sim/touch_sample_filter_affine_map_top_tb.sv */
// touch_sample_filter_affine_map_top_tb: stimulus and verdict for the touch filter and mapper
// drives polls, calibration writes and result back-pressure; checking lives in touch_event_checker
// depends on tsfam_pkg, touch_sample_filter_affine_map_top, touch_event_checker
module touch_sample_filter_affine_map_top_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import tsfam_pkg::*;

	// address slot past the register list, writes there must be ignored
	localparam logic [2:0] REG_SPARE = 3'd7;

	// one touch poll as the request channel carries it
	typedef struct packed {
		logic    pen;
		sample_t z1;
		sample_t z2;
		sample_t x1;
		sample_t x2;
		sample_t x3;
		sample_t y1;
		sample_t y2;
		sample_t y3;
	} touch_poll_t;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [S_TDATA_W-1:0]  s_tdata;
	logic                  s_tuser;
	logic                  m_tvalid;
	logic                  m_tready;
	logic [M_TDATA_W-1:0]  m_tdata;
	logic                  m_tuser;
	logic                  psel;
	logic                  penable;
	logic                  pwrite;
	logic [PADDR_W-1:0]    paddr;
	logic [PDATA_W-1:0]    pwdata;
	logic [PDATA_W-1:0]    prdata;
	logic                  pready;

	int fail_count;
	int pending;      // results still owed by the block
	bit calm;         // no idling on either side while set
	int stall_req;    // long hold-off asked of the result side, in cycles

	always #5 clk = ~clk;

	touch_sample_filter_affine_map_top dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	touch_event_checker checker_i (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tuser    (m_tuser),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.pready     (pready),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.fail_count (fail_count),
		.pending    (pending)
	);

	function automatic int clamp12(input int v);
		return (v < 0) ? 0 : ((v > 4095) ? 4095 : v);
	endfunction

	function automatic touch_poll_t make_poll(input bit pen, input int z1, input int z2,
			input int x1, input int x2, input int x3, input int y1, input int y2, input int y3);
		touch_poll_t p;
		p.pen = pen;
		p.z1 = sample_t'(z1);
		p.z2 = sample_t'(z2);
		p.x1 = sample_t'(x1);
		p.x2 = sample_t'(x2);
		p.x3 = sample_t'(x3);
		p.y1 = sample_t'(y1);
		p.y2 = sample_t'(y2);
		p.y3 = sample_t'(y3);
		return p;
	endfunction

	// any field value at all, pen state included
	function automatic touch_poll_t noise_poll();
		return make_poll($urandom_range(0, 1), $urandom_range(0, 4095), $urandom_range(0, 4095),
			$urandom_range(0, 4095), $urandom_range(0, 4095), $urandom_range(0, 4095),
			$urandom_range(0, 4095), $urandom_range(0, 4095), $urandom_range(0, 4095));
	endfunction

	// one conversion near the true position, now and then a wild outlier for the median
	function automatic int jitter(input int base);
		if ($urandom_range(0, 7) == 0) begin
			return $urandom_range(0, 4095);
		end
		return clamp12(base + int'($urandom_range(0, 16)) - 8);
	endfunction

	// plausible pen-down poll: pressure ratio mostly below two, sometimes anything
	function automatic touch_poll_t stroke_poll(input int bx, input int by);
		int z1;
		int z2;
		int sel;
		z1 = ($urandom_range(0, 15) == 0) ? 0 : $urandom_range(1, 4095);
		sel = $urandom_range(0, 9);
		if (z1 == 0 || sel >= 7) begin
			z2 = $urandom_range(0, 4095);
		end else if (sel == 6) begin
			z2 = $urandom_range(0, z1 - 1);
		end else begin
			z2 = $urandom_range(z1, clamp12(2 * z1 - 1));
		end
		return make_poll(1'b1, z1, z2, jitter(bx), jitter(bx), jitter(bx),
			jitter(by), jitter(by), jitter(by));
	endfunction

	// request side: random gap, then offer until taken; returns on a falling edge
	task automatic send_poll(input touch_poll_t p);
		int gap;
		gap = calm ? 0 : $urandom_range(0, 7);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= p.pen;
		s_tdata  <= {p.y3, p.y2, p.y1, p.x3, p.x2, p.x1, p.z2, p.z1};
		do @(posedge clk); while (!s_tready);
		@(negedge clk);
	endtask

	// drain every owed result, then let a silent poll finish inside the block
	task automatic settle();
		s_tvalid <= 1'b0;
		wait (pending == 0);
		repeat (40) @(negedge clk);
	endtask

	// setup phase, then access phase, then idle with psel low
	task automatic write_calibration(input logic [2:0] idx, input logic [PDATA_W-1:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= value;
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(negedge clk);
	endtask

	// gains and offsets: extremes, zero, full random or a realistic gain of either sign
	function automatic logic [PDATA_W-1:0] rand_coef();
		logic [PDATA_W-1:0] v;
		case ($urandom_range(0, 6))
			0: v = 32'h7FFF_FFFF;
			1: v = 32'h8000_0000;
			2: v = '0;
			3, 4: v = $urandom;
			default: begin
				v = $urandom_range(0, 1 << 20);
				if ($urandom_range(0, 1)) begin
					v = -v;
				end
			end
		endcase
		return v;
	endfunction

	// limit: extremes, the reset value 16384, small values, or junk in the unused top bits
	function automatic logic [PDATA_W-1:0] rand_limit();
		case ($urandom_range(0, 5))
			0: return '0;
			1: return 32'h07FF_FFFF;
			2: return 32'd16384;
			3: return $urandom_range(0, 1 << 17);
			default: return $urandom;
		endcase
	endfunction

	task automatic randomise_calibration();
		write_calibration(REG_CXX, rand_coef());
		write_calibration(REG_CXY, rand_coef());
		write_calibration(REG_OX, rand_coef());
		write_calibration(REG_CYX, rand_coef());
		write_calibration(REG_CYY, rand_coef());
		write_calibration(REG_OY, rand_coef());
		write_calibration(REG_LIMIT, rand_limit());
	endtask

	// mostly whole strokes (pen-down polls drifting about, then lift), some pure noise
	task automatic random_traffic(input int polls_wanted);
		int sent;
		int len;
		int bx;
		int by;
		sent = 0;
		while (sent < polls_wanted) begin
			if ($urandom_range(0, 6) == 0) begin
				send_poll(noise_poll());
				sent++;
			end else begin
				bx  = $urandom_range(0, 4095);
				by  = $urandom_range(0, 4095);
				len = $urandom_range(1, 8);
				repeat (len) begin
					bx = clamp12(bx + int'($urandom_range(0, 64)) - 32);
					by = clamp12(by + int'($urandom_range(0, 64)) - 32);
					send_poll(stroke_poll(bx, by));
					sent++;
				end
				// lift, and now and then a second lift that must stay silent
				send_poll(make_poll(1'b0, $urandom_range(0, 4095), $urandom_range(0, 4095),
					$urandom_range(0, 4095), $urandom_range(0, 4095), $urandom_range(0, 4095),
					$urandom_range(0, 4095), $urandom_range(0, 4095), $urandom_range(0, 4095)));
				sent++;
				if ($urandom_range(0, 5) == 0) begin
					send_poll(make_poll(1'b0, 0, 0, 0, 0, 0, 0, 0, 0));
					sent++;
				end
			end
		end
	endtask

	// result side: random hold-off per result, plus a long hold-off on request
	initial begin
		int n;
		int gap;
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (stall_req > 0) begin
				// long hold-off: the block fills up and has to refuse requests
				m_tready <= 1'b0;
				n = stall_req;
				stall_req = 0;
				repeat (n) @(negedge clk);
			end
			gap = calm ? 0 : $urandom_range(0, 7);
			if (gap > 0) begin
				m_tready <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!(m_tvalid && m_tready));
		end
	end

	// hard stop well beyond the slowest correct run
	initial begin
		#5_000_000;
		$display("TEST FAILED");
		$finish;
	end

	initial begin
		arst_n    = 1'b0;
		s_tvalid  = 1'b0;
		s_tdata   = '0;
		s_tuser   = 1'b0;
		psel      = 1'b0;
		penable   = 1'b0;
		pwrite    = 1'b0;
		paddr     = '0;
		pwdata    = '0;
		calm      = 1'b0;
		stall_req = 0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed part under the reset calibration
		// lift with nothing pressed: silent
		send_poll(make_poll(1'b0, 4095, 4095, 4095, 4095, 4095, 4095, 4095, 4095));
		// zero first pressure: rejected outright
		send_poll(make_poll(1'b1, 0, 4095, 4095, 4095, 4095, 0, 0, 0));
		// pressure ratio below one gives a negative contact value, always accepted
		send_poll(make_poll(1'b1, 1, 0, 4095, 4095, 4095, 0, 0, 0));
		send_poll(make_poll(1'b1, 4095, 4095, 0, 0, 0, 4095, 4095, 4095));
		send_poll(make_poll(1'b1, 4095, 0, 4095, 4095, 4095, 4095, 4095, 4095));
		// contact far above the limit while pressed: silent, state kept
		send_poll(make_poll(1'b1, 1, 4095, 2000, 2000, 2000, 1000, 1000, 1000));
		// ratio two: 5*3276 just inside the limit, 5*3277 just outside
		send_poll(make_poll(1'b1, 100, 200, 3276, 3276, 3276, 1500, 1500, 1500));
		send_poll(make_poll(1'b1, 100, 200, 3277, 3277, 3277, 1500, 1500, 1500));
		// median in every position, and with ties
		send_poll(make_poll(1'b1, 2000, 2100, 10, 20, 30, 300, 100, 200));
		send_poll(make_poll(1'b1, 2000, 2100, 30, 10, 20, 200, 300, 100));
		send_poll(make_poll(1'b1, 2000, 2100, 20, 30, 10, 100, 200, 300));
		send_poll(make_poll(1'b1, 2000, 2100, 5, 5, 9, 9, 5, 9));
		send_poll(make_poll(1'b1, 2000, 2100, 9, 5, 5, 4095, 0, 2048));
		// lift releases the last press, second lift is silent
		send_poll(make_poll(1'b0, 0, 0, 0, 0, 0, 0, 0, 0));
		send_poll(make_poll(1'b0, 0, 0, 0, 0, 0, 0, 0, 0));
		send_poll(make_poll(1'b1, 1, 1, 0, 0, 0, 0, 0, 0));
		send_poll(make_poll(1'b0, 1, 1, 0, 0, 0, 0, 0, 0));
		settle();

		// everything at the top: mapping saturates high away from the origin, every contact accepted
		write_calibration(REG_CXX, 32'h7FFF_FFFF);
		write_calibration(REG_CXY, 32'h7FFF_FFFF);
		write_calibration(REG_OX, 32'h7FFF_FFFF);
		write_calibration(REG_CYX, 32'h7FFF_FFFF);
		write_calibration(REG_CYY, 32'h7FFF_FFFF);
		write_calibration(REG_OY, 32'h7FFF_FFFF);
		write_calibration(REG_LIMIT, 32'hFFFF_FFFF);
		send_poll(make_poll(1'b1, 1, 4095, 4095, 4095, 4095, 4095, 4095, 4095));
		send_poll(make_poll(1'b1, 4095, 4095, 0, 0, 0, 0, 0, 0));
		send_poll(make_poll(1'b0, 0, 0, 0, 0, 0, 0, 0, 0));
		settle();

		// everything at the bottom: saturates low; zero limit takes only zero contact
		write_calibration(REG_CXX, 32'h8000_0000);
		write_calibration(REG_CXY, 32'h8000_0000);
		write_calibration(REG_OX, 32'h8000_0000);
		write_calibration(REG_CYX, 32'h8000_0000);
		write_calibration(REG_CYY, 32'h8000_0000);
		write_calibration(REG_OY, 32'h8000_0000);
		write_calibration(REG_LIMIT, 32'h0000_0000);
		write_calibration(REG_SPARE, $urandom);
		send_poll(make_poll(1'b1, 1000, 1500, 4095, 4095, 4095, 4095, 4095, 4095));
		send_poll(make_poll(1'b1, 1000, 2000, 1, 1, 1, 0, 0, 0));
		send_poll(make_poll(1'b1, 1000, 2000, 0, 0, 0, 4095, 4095, 4095));
		send_poll(make_poll(1'b0, 0, 0, 0, 0, 0, 0, 0, 0));
		settle();

		// random phases, each with a fresh calibration
		for (int phase = 0; phase < 8; phase++) begin
			randomise_calibration();
			calm = (phase == 2);
			if (phase == 3) begin
				// receiver goes quiet for a long stretch while requests keep coming
				random_traffic(20);
				stall_req = 300;
				random_traffic(40);
			end else if (phase == 4) begin
				// sender pauses until the block owes nothing
				random_traffic(30);
				s_tvalid <= 1'b0;
				wait (pending == 0);
				@(negedge clk);
				random_traffic(30);
			end else begin
				random_traffic(60);
			end
			calm = 1'b0;
			settle();
		end

		if (fail_count == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule

/* sim.f */
rtl/tsfam_pkg.sv
rtl/touch_sample_filter_affine_map_top.sv
sim/touch_event_checker.sv
sim/touch_sample_filter_affine_map_top_tb.sv
